// File: sv/alr_pkg.sv
package alr_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pix_x;
    logic [7:0] pix_y;
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
    logic       line_end;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic       CMD_START  = 1'b0;
  localparam logic       CMD_ADV    = 1'b1;

  localparam logic [1:0] KIND_VERT  = 2'd0;
  localparam logic [1:0] KIND_HORZ  = 2'd1;
  localparam logic [1:0] KIND_DIAG  = 2'd2;
  localparam logic [1:0] KIND_GEN   = 2'd3;

  localparam logic [7:0] FULL_INTEN = 8'hFF;

  localparam logic       SEL_A      = 1'b0;
  localparam logic       SEL_B      = 1'b1;

endpackage

// File: sv/alr_in_if.sv
interface alr_in_if;
  logic               valid;
  logic               ready;
  alr_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/alr_out_if.sv
interface alr_out_if;
  logic               valid;
  logic               ready;
  alr_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/alr_div.sv
// restoring divider: quot = num*256/den, num < den
module alr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [7:0]         num,
  input  logic [7:0]         den,
  output alr_pkg::div_stat_t stat,
  output logic [7:0]         quot
);

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] den_r, den_nxt;
  logic [7:0] quot_r, quot_nxt;
  logic [8:0] rem2;
  logic       ge;

  assign rem2 = {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      rem_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = 8'(rem2 - {1'b0, den_r});
      end else begin
        rem_nxt = rem2[7:0];
      end
      quot_nxt = {quot_r[6:0], ge};
      cnt_nxt  = 3'(cnt_r + 3'd1);
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;

endmodule

// File: sv/alr_scale.sv
// q = floor(chan*inten/255), registered
module alr_scale (
  input  logic       clk,
  input  logic [7:0] chan,
  input  logic [7:0] inten,
  output logic [7:0] q
);

  logic [15:0] prod;
  logic [15:0] sum;
  logic [7:0]  q_r;

  assign prod = 16'(chan) * 16'(inten);
  assign sum  = 16'(prod + {8'd0, prod[15:8]} + 16'd1);

  always_ff @(posedge clk) begin
    q_r <= sum[15:8];
  end

  assign q = q_r;

endmodule

// File: sv/antialiased_line_rasterizer_core.sv
// channel  dir  handshake          word
// in_ch    in   valid/ready        cmd, endpoints, colour
// out_ch   out  valid/ready        pixel x/y, scaled colour, line_end
//
// Start word: accepted in S_IDLE, sorted in S_SORT and set up in S_SETUP, then the
// scaler runs in S_SCALE (a general line also waits for the 8-step divider), then
// 2 pixel words, one per cycle while out_ch is ready.
// Advance word: accept, step, pixel list and scaler states, then 1 or 4 pixel
// words. An advance on an idle line is taken and gives nothing.
// in_ch.ready is high only when idle; a stalled out_ch holds the sequencer.
// rst_n is synchronous and clears the sequencer and line state.
module antialiased_line_rasterizer_core (
  input  logic             clk,
  input  logic             rst_n,
  alr_in_if.sink           in_ch,
  alr_out_if.source        out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SORT  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_PLIST = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  alr_pkg::in_word_t item_r, item_nxt;

  // sorted endpoints
  logic [7:0] sx0_r, sx0_nxt, sy0_r, sy0_nxt, sx1_r, sx1_nxt, sy1_r, sy1_nxt;
  logic [7:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic       neg_r, neg_nxt;

  // line state
  logic [7:0]  near_x_r, near_x_nxt, near_y_r, near_y_nxt;
  logic [7:0]  far_x_r, far_x_nxt, far_y_r, far_y_nxt;
  logic [7:0]  frac_acc_r, frac_acc_nxt, frac_step_r, frac_step_nxt;
  logic        slope_neg_r, slope_neg_nxt, steep_r, steep_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  run_left_r, run_left_nxt, walk_y_r, walk_y_nxt;
  logic [23:0] color_r, color_nxt;
  logic        busy_r, busy_nxt;

  // pixel list
  logic [7:0] ent_x_r [4];
  logic [7:0] ent_y_r [4];
  logic       ent_sel_r [4];
  logic [7:0] ent_x_nxt [4];
  logic [7:0] ent_y_nxt [4];
  logic       ent_sel_nxt [4];
  logic [1:0] ent_last_r, ent_last_nxt;
  logic       last_flag_r, last_flag_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] inten_a_r, inten_a_nxt, inten_b_r, inten_b_nxt;

  // scaled colours, index 0 = intensity A, 1 = intensity B
  logic [7:0] red_r [2];
  logic [7:0] green_r [2];
  logic [7:0] blue_r [2];
  logic [2:0] scnt_r, scnt_nxt;

  // shared units
  logic               div_start;
  logic [7:0]         div_num, div_den, div_quot;
  alr_pkg::div_stat_t div_stat;
  logic [7:0]         sc_chan, sc_inten, sc_q;

  alr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  alr_scale u_scale (
    .clk   (clk),
    .chan  (sc_chan),
    .inten (sc_inten),
    .q     (sc_q)
  );

  // scaler operand select
  always_comb begin
    sc_inten = (scnt_r < 3'd3) ? inten_a_r : inten_b_r;
    case (scnt_r)
      3'd0, 3'd3: sc_chan = color_r[23:16];
      3'd1, 3'd4: sc_chan = color_r[15:8];
      default:    sc_chan = color_r[7:0];
    endcase
  end

  // set-up and step helpers
  logic       gen_line, steep_new, setup_busy;
  logic [1:0] setup_kind;
  logic [7:0] setup_len, setup_run;
  logic [7:0] acc_sum, nx_step, fx_step;
  logic [7:0] a0, b0, a1, b1;
  logic       da, db;
  logic [7:0] run_dec;

  always_comb begin
    gen_line   = !(dx_r == 8'd0 || dy_r == 8'd0 || dx_r == dy_r);
    steep_new  = dy_r > dx_r;
    setup_kind = (dx_r == 8'd0) ? alr_pkg::KIND_VERT :
                 (dy_r == 8'd0) ? alr_pkg::KIND_HORZ : alr_pkg::KIND_DIAG;
    setup_len  = (dx_r == 8'd0) ? dy_r : dx_r;
    setup_run  = (setup_len >= 8'd2) ? 8'(setup_len - 8'd1) : 8'd0;
    setup_busy = gen_line || (setup_run != 8'd0);
    div_num    = steep_new ? dx_r : dy_r;
    div_den    = steep_new ? dy_r : dx_r;
    acc_sum    = 8'(frac_acc_r + frac_step_r);
    nx_step    = 8'(near_x_r + 8'd1);
    fx_step    = 8'(far_x_r - 8'd1);
    run_dec    = 8'(run_left_r - 8'd1);

    a0 = near_x_r;
    b0 = near_y_r;
    a1 = far_x_r;
    b1 = far_y_r;
    da = 1'b0;
    db = 1'b1;
    if (slope_neg_r && !steep_r) begin
      a0 = far_x_r;
      a1 = near_x_r;
    end else if (steep_r) begin
      a0 = near_y_r;
      a1 = far_y_r;
      b0 = slope_neg_r ? far_x_r : near_x_r;
      b1 = slope_neg_r ? near_x_r : far_x_r;
      da = 1'b1;
      db = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    sx0_nxt       = sx0_r;
    sy0_nxt       = sy0_r;
    sx1_nxt       = sx1_r;
    sy1_nxt       = sy1_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    neg_nxt       = neg_r;
    near_x_nxt    = near_x_r;
    near_y_nxt    = near_y_r;
    far_x_nxt     = far_x_r;
    far_y_nxt     = far_y_r;
    frac_acc_nxt  = frac_acc_r;
    frac_step_nxt = div_stat.done ? div_quot : frac_step_r;
    slope_neg_nxt = slope_neg_r;
    steep_nxt     = steep_r;
    kind_nxt      = kind_r;
    run_left_nxt  = run_left_r;
    walk_y_nxt    = walk_y_r;
    color_nxt     = color_r;
    busy_nxt      = busy_r;
    ent_last_nxt  = ent_last_r;
    last_flag_nxt = last_flag_r;
    idx_nxt       = idx_r;
    inten_a_nxt   = inten_a_r;
    inten_b_nxt   = inten_b_r;
    scnt_nxt      = scnt_r;
    div_start     = 1'b0;
    for (int i = 0; i < 4; i++) begin
      ent_x_nxt[i]   = ent_x_r[i];
      ent_y_nxt[i]   = ent_y_r[i];
      ent_sel_nxt[i] = ent_sel_r[i];
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt = in_ch.data;
          if (in_ch.data.cmd == alr_pkg::CMD_START) begin
            state_nxt = S_SORT;
          end else if (busy_r) begin
            state_nxt = S_STEP;
          end
        end
      end

      S_SORT: begin
        logic [7:0] y0, y1, x0, x1;
        logic       n;
        n  = item_r.y_start > item_r.y_end;
        y0 = n ? item_r.y_end : item_r.y_start;
        y1 = n ? item_r.y_start : item_r.y_end;
        x0 = item_r.x_start;
        x1 = item_r.x_end;
        if (item_r.x_start > item_r.x_end) begin
          x0 = item_r.x_end;
          x1 = item_r.x_start;
          n  = !n;
        end
        sx0_nxt   = x0;
        sx1_nxt   = x1;
        sy0_nxt   = y0;
        sy1_nxt   = y1;
        dx_nxt    = 8'(x1 - x0);
        dy_nxt    = 8'(y1 - y0);
        neg_nxt   = n;
        color_nxt = {item_r.in_red, item_r.in_green, item_r.in_blue};
        state_nxt = S_SETUP;
      end

      S_SETUP: begin
        slope_neg_nxt = neg_r;
        steep_nxt     = 1'b0;
        busy_nxt      = setup_busy;
        if (gen_line) begin
          kind_nxt     = alr_pkg::KIND_GEN;
          steep_nxt    = steep_new;
          near_x_nxt   = steep_new ? sy0_r : sx0_r;
          near_y_nxt   = steep_new ? sx0_r : sy0_r;
          far_x_nxt    = steep_new ? sy1_r : sx1_r;
          far_y_nxt    = steep_new ? sx1_r : sy1_r;
          frac_acc_nxt = 8'd0;
          div_start    = 1'b1;
        end else begin
          kind_nxt     = setup_kind;
          near_x_nxt   = sx0_r;
          walk_y_nxt   = (setup_kind == alr_pkg::KIND_DIAG && neg_r) ? sy1_r : sy0_r;
          run_left_nxt = setup_run;
        end
        ent_x_nxt[0]   = item_r.x_start;
        ent_y_nxt[0]   = item_r.y_start;
        ent_sel_nxt[0] = alr_pkg::SEL_A;
        ent_x_nxt[1]   = item_r.x_end;
        ent_y_nxt[1]   = item_r.y_end;
        ent_sel_nxt[1] = alr_pkg::SEL_A;
        ent_last_nxt   = 2'd1;
        last_flag_nxt  = !setup_busy;
        inten_a_nxt    = alr_pkg::FULL_INTEN;
        inten_b_nxt    = alr_pkg::FULL_INTEN;
        scnt_nxt       = 3'd0;
        state_nxt      = S_SCALE;
      end

      S_STEP: begin
        if (kind_r == alr_pkg::KIND_GEN) begin
          near_x_nxt   = nx_step;
          far_x_nxt    = fx_step;
          frac_acc_nxt = acc_sum;
          if (frac_acc_r > acc_sum) begin
            near_y_nxt = 8'(near_y_r + 8'd1);
            far_y_nxt  = 8'(far_y_r - 8'd1);
          end
          busy_nxt = nx_step < fx_step;
        end else begin
          case (kind_r)
            alr_pkg::KIND_VERT: walk_y_nxt = 8'(walk_y_r + 8'd1);
            alr_pkg::KIND_HORZ: near_x_nxt = nx_step;
            default: begin
              near_x_nxt = nx_step;
              walk_y_nxt = slope_neg_r ? 8'(walk_y_r - 8'd1) : 8'(walk_y_r + 8'd1);
            end
          endcase
          run_left_nxt = run_dec;
          busy_nxt     = run_dec != 8'd0;
        end
        state_nxt = S_PLIST;
      end

      S_PLIST: begin
        last_flag_nxt = !busy_r;
        scnt_nxt      = 3'd0;
        state_nxt     = S_SCALE;
        if (kind_r == alr_pkg::KIND_GEN) begin
          ent_x_nxt[0]   = a0;
          ent_y_nxt[0]   = b0;
          ent_sel_nxt[0] = alr_pkg::SEL_A;
          ent_x_nxt[1]   = 8'(a0 + {7'd0, da});
          ent_y_nxt[1]   = 8'(b0 + {7'd0, db});
          ent_sel_nxt[1] = alr_pkg::SEL_B;
          ent_x_nxt[2]   = a1;
          ent_y_nxt[2]   = b1;
          ent_sel_nxt[2] = alr_pkg::SEL_A;
          ent_x_nxt[3]   = 8'(a1 - {7'd0, da});
          ent_y_nxt[3]   = 8'(b1 - {7'd0, db});
          ent_sel_nxt[3] = alr_pkg::SEL_B;
          ent_last_nxt   = 2'd3;
          inten_a_nxt    = 8'(alr_pkg::FULL_INTEN - frac_acc_r);
          inten_b_nxt    = frac_acc_r;
        end else begin
          ent_x_nxt[0]   = near_x_r;
          ent_y_nxt[0]   = walk_y_r;
          ent_sel_nxt[0] = alr_pkg::SEL_A;
          ent_last_nxt   = 2'd0;
          inten_a_nxt    = alr_pkg::FULL_INTEN;
          inten_b_nxt    = alr_pkg::FULL_INTEN;
        end
      end

      S_SCALE: begin
        if (scnt_r != 3'd6) begin
          scnt_nxt = 3'(scnt_r + 3'd1);
        end else if (!div_stat.busy) begin
          idx_nxt   = 2'd0;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_ch.ready) begin
          idx_nxt = 2'(idx_r + 2'd1);
          if (idx_r == ent_last_r) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      near_x_r    <= 8'd0;
      near_y_r    <= 8'd0;
      far_x_r     <= 8'd0;
      far_y_r     <= 8'd0;
      frac_acc_r  <= 8'd0;
      frac_step_r <= 8'd0;
      slope_neg_r <= 1'b0;
      steep_r     <= 1'b0;
      kind_r      <= alr_pkg::KIND_VERT;
      run_left_r  <= 8'd0;
      walk_y_r    <= 8'd0;
      color_r     <= 24'd0;
      busy_r      <= 1'b0;
      idx_r       <= 2'd0;
      scnt_r      <= 3'd0;
    end else begin
      state_r     <= state_nxt;
      near_x_r    <= near_x_nxt;
      near_y_r    <= near_y_nxt;
      far_x_r     <= far_x_nxt;
      far_y_r     <= far_y_nxt;
      frac_acc_r  <= frac_acc_nxt;
      frac_step_r <= frac_step_nxt;
      slope_neg_r <= slope_neg_nxt;
      steep_r     <= steep_nxt;
      kind_r      <= kind_nxt;
      run_left_r  <= run_left_nxt;
      walk_y_r    <= walk_y_nxt;
      color_r     <= color_nxt;
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      scnt_r      <= scnt_nxt;
    end
    item_r      <= item_nxt;
    sx0_r       <= sx0_nxt;
    sy0_r       <= sy0_nxt;
    sx1_r       <= sx1_nxt;
    sy1_r       <= sy1_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    neg_r       <= neg_nxt;
    ent_last_r  <= ent_last_nxt;
    last_flag_r <= last_flag_nxt;
    inten_a_r   <= inten_a_nxt;
    inten_b_r   <= inten_b_nxt;
    for (int i = 0; i < 4; i++) begin
      ent_x_r[i]   <= ent_x_nxt[i];
      ent_y_r[i]   <= ent_y_nxt[i];
      ent_sel_r[i] <= ent_sel_nxt[i];
    end
  end

  // scaler results land in the cycle after issue
  always_ff @(posedge clk) begin
    if (state_r == S_SCALE) begin
      case (scnt_r)
        3'd1:    red_r[0]   <= sc_q;
        3'd2:    green_r[0] <= sc_q;
        3'd3:    blue_r[0]  <= sc_q;
        3'd4:    red_r[1]   <= sc_q;
        3'd5:    green_r[1] <= sc_q;
        3'd6:    blue_r[1]  <= sc_q;
        default: ;
      endcase
    end
  end

  logic sel;
  assign sel = ent_sel_r[idx_r];

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = (state_r == S_EMIT);
  assign out_ch.data.pix_x        = ent_x_r[idx_r];
  assign out_ch.data.pix_y        = ent_y_r[idx_r];
  assign out_ch.data.pix_red      = red_r[sel];
  assign out_ch.data.pix_green    = green_r[sel];
  assign out_ch.data.pix_blue     = blue_r[sel];
  assign out_ch.data.line_end     = last_flag_r && (idx_r == ent_last_r);

  // no word taken while pixels are pending
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while output word pending");

  // quotient settled before any pixel goes out
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !div_stat.busy)
    else $error("divider still busy during emit");

  // advance on an idle line produces nothing
  a_idle_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.data.cmd == alr_pkg::CMD_ADV && !busy_r)
      |=> in_ch.ready)
    else $error("advance on idle line left idle state");

  // line end only once the line has no pixels left
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.line_end) |-> !busy_r)
    else $error("line end flagged on an active line");

endmodule

// File: test/antialiased_line_rasterizer_core_test.sv
module antialiased_line_rasterizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 480;
  localparam int CALM_FROM = 3000;
  localparam int CALM_TO = 5000;
  localparam int HOLD_AT = 1500;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;

  logic clk;
  logic rst_n;

  alr_in_if  in_ch ();
  alr_out_if out_ch ();

  antialiased_line_rasterizer_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  alr_pkg::in_word_t  word_queue[$];
  alr_pkg::out_word_t due_pixels[$];

  // line state of the predictor
  logic [7:0]  lead_x, lead_y, tail_x, tail_y;
  logic [7:0]  wu_frac, wu_frac_last, wu_step;
  logic [7:0]  steps_left, run_y;
  logic        mirrored, steep, line_live;
  logic [1:0]  line_shape;
  logic [23:0] colour;

  int shape_tally[4];
  int words_taken;
  int pixels_seen;
  int error_count;
  int send_cycles;
  int recv_cycles;
  int hold_left;
  int watch_cycles;

  function automatic logic [7:0] dim(input logic [7:0] c, input logic [7:0] i);
    logic [15:0] p;
    p = c * i;
    return 8'(p / 16'd255);
  endfunction

  task automatic push_pixel(input logic [7:0] x, input logic [7:0] y,
                            input logic [7:0] inten, input logic last);
    alr_pkg::out_word_t p;
    p.pix_x = x;
    p.pix_y = y;
    p.pix_red = dim(colour[23:16], inten);
    p.pix_green = dim(colour[15:8], inten);
    p.pix_blue = dim(colour[7:0], inten);
    p.line_end = last;
    due_pixels.push_back(p);
  endtask

  task automatic raster_word(input alr_pkg::in_word_t w);
    logic [7:0] x0, y0, x1, y1, t, dx, dy, len, a0, b0, a1, b1, inv;
    logic       neg, da, db;
    if (w.cmd == alr_pkg::CMD_START) begin
      colour = {w.in_red, w.in_green, w.in_blue};
      push_pixel(w.x_start, w.y_start, alr_pkg::FULL_INTEN, 1'b0);
      x0 = w.x_start;
      y0 = w.y_start;
      x1 = w.x_end;
      y1 = w.y_end;
      neg = y0 > y1;
      if (neg) begin
        t = y0; y0 = y1; y1 = t;
      end
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        neg = !neg;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      mirrored = neg;
      steep = 1'b0;
      if (dx == 8'd0 || dy == 8'd0 || dx == dy) begin
        len = (dx == 8'd0) ? dy : dx;
        line_shape = (dx == 8'd0) ? alr_pkg::KIND_VERT :
                     (dy == 8'd0) ? alr_pkg::KIND_HORZ : alr_pkg::KIND_DIAG;
        lead_x = x0;
        run_y = (line_shape == alr_pkg::KIND_DIAG && neg) ? y1 : y0;
        steps_left = (len >= 8'd2) ? len - 8'd1 : 8'd0;
        line_live = steps_left != 8'd0;
      end else begin
        line_shape = alr_pkg::KIND_GEN;
        if (dy > dx) begin
          steep = 1'b1;
          t = x0; x0 = y0; y0 = t;
          t = x1; x1 = y1; y1 = t;
          t = dx; dx = dy; dy = t;
        end
        lead_x = x0;
        lead_y = y0;
        tail_x = x1;
        tail_y = y1;
        wu_step = 8'({dy, 8'd0} / {8'd0, dx});
        wu_frac = 8'd0;
        wu_frac_last = 8'd0;
        line_live = 1'b1;
      end
      shape_tally[line_shape]++;
      push_pixel(w.x_end, w.y_end, alr_pkg::FULL_INTEN, !line_live);
    end else if (line_live) begin
      if (line_shape != alr_pkg::KIND_GEN) begin
        if (line_shape == alr_pkg::KIND_VERT) begin
          run_y = run_y + 8'd1;
        end else if (line_shape == alr_pkg::KIND_HORZ) begin
          lead_x = lead_x + 8'd1;
        end else begin
          lead_x = lead_x + 8'd1;
          run_y = mirrored ? run_y - 8'd1 : run_y + 8'd1;
        end
        steps_left = steps_left - 8'd1;
        line_live = steps_left != 8'd0;
        push_pixel(lead_x, run_y, alr_pkg::FULL_INTEN, !line_live);
      end else begin
        lead_x = lead_x + 8'd1;
        tail_x = tail_x - 8'd1;
        wu_frac = wu_frac + wu_step;
        if (wu_frac_last > wu_frac) begin
          lead_y = lead_y + 8'd1;
          tail_y = tail_y - 8'd1;
        end
        wu_frac_last = wu_frac;
        a0 = lead_x; b0 = lead_y; a1 = tail_x; b1 = tail_y;
        da = 1'b0;
        db = 1'b1;
        if (mirrored && !steep) begin
          t = a0; a0 = a1; a1 = t;
        end else if (steep) begin
          t = a0; a0 = b0; b0 = t;
          t = a1; a1 = b1; b1 = t;
          if (mirrored) begin
            t = b0; b0 = b1; b1 = t;
          end
          da = 1'b1;
          db = 1'b0;
        end
        inv = alr_pkg::FULL_INTEN - wu_frac;
        line_live = lead_x < tail_x;
        push_pixel(a0, b0, inv, 1'b0);
        push_pixel(a0 + 8'(da), b0 + 8'(db), wu_frac, 1'b0);
        push_pixel(a1, b1, inv, 1'b0);
        push_pixel(a1 - 8'(da), b1 - 8'(db), wu_frac, !line_live);
      end
    end
  endtask

  task automatic add_start(input int x0, input int y0, input int x1, input int y1,
                           input int r, input int g, input int b);
    alr_pkg::in_word_t w;
    w.cmd = alr_pkg::CMD_START;
    w.x_start = 8'(x0);
    w.y_start = 8'(y0);
    w.x_end = 8'(x1);
    w.y_end = 8'(y1);
    w.in_red = 8'(r);
    w.in_green = 8'(g);
    w.in_blue = 8'(b);
    word_queue.push_back(w);
  endtask

  // advance words carry random junk in the unused fields
  task automatic add_advances(input int n);
    alr_pkg::in_word_t w;
    repeat (n) begin
      w.cmd = alr_pkg::CMD_ADV;
      w.x_start = 8'($urandom_range(0, 255));
      w.y_start = 8'($urandom_range(0, 255));
      w.x_end = 8'($urandom_range(0, 255));
      w.y_end = 8'($urandom_range(0, 255));
      w.in_red = 8'($urandom_range(0, 255));
      w.in_green = 8'($urandom_range(0, 255));
      w.in_blue = 8'($urandom_range(0, 255));
      word_queue.push_back(w);
    end
  endtask

  function automatic int pick_end(input int p, input int d);
    int lo, hi;
    lo = p - d;
    hi = p + d;
    if (hi <= 255 && lo >= 0) return ($urandom_range(0, 1) != 0) ? hi : lo;
    if (hi <= 255) return hi;
    if (lo >= 0) return lo;
    return (p < 128) ? 255 : 0;
  endfunction

  // sender
  always @(posedge clk) begin : drive
    logic offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      send_cycles++;
      offer = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        void'(word_queue.pop_front());
        offer = 1'b0;
      end
      if (!offer && word_queue.size() != 0) begin
        offer = (send_cycles >= CALM_FROM && send_cycles < CALM_TO) ||
                $urandom_range(0, 99) >= 9;
      end
      in_ch.valid <= offer;
      if (offer) in_ch.data <= word_queue[0];
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(posedge clk) begin : receive
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      recv_cycles++;
      if (hold_left != 0) hold_left--;
      else if (recv_cycles == HOLD_AT) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (recv_cycles >= CALM_FROM && recv_cycles < CALM_TO) ||
                        $urandom_range(0, 99) >= 9;
      end
    end
  end

  // prediction on accepted input, check on accepted output
  always @(posedge clk) begin : watch
    alr_pkg::out_word_t want, got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        raster_word(in_ch.data);
        words_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        pixels_seen++;
        if (due_pixels.size() == 0) begin
          if (error_count < 10)
            $display("unexpected pixel word x=%0d y=%0d rgb=%02h%02h%02h end=%0b",
                     got.pix_x, got.pix_y, got.pix_red, got.pix_green, got.pix_blue,
                     got.line_end);
          error_count++;
        end else begin
          want = due_pixels.pop_front();
          if (got.pix_x !== want.pix_x || got.pix_y !== want.pix_y ||
              got.pix_red !== want.pix_red || got.pix_green !== want.pix_green ||
              got.pix_blue !== want.pix_blue || got.line_end !== want.line_end) begin
            if (error_count < 10)
              $display("pixel %0d: want %0d,%0d %02h%02h%02h e%0b got %0d,%0d %02h%02h%02h e%0b",
                       pixels_seen, want.pix_x, want.pix_y, want.pix_red, want.pix_green,
                       want.pix_blue, want.line_end, got.pix_x, got.pix_y, got.pix_red,
                       got.pix_green, got.pix_blue, got.line_end);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    watch_cycles++;
    if (watch_cycles == CYCLE_LIMIT) begin
      $display("timed out with %0d pixel words outstanding", due_pixels.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int random_items, span, shape, x0, y0, x1, y1, ddx, ddy, adx, ady, len, need, steps;
    logic longish;
    rst_n = 1'b0;
    lead_x = '0; lead_y = '0; tail_x = '0; tail_y = '0;
    wu_frac = '0; wu_frac_last = '0; wu_step = '0;
    steps_left = '0; run_y = '0;
    mirrored = 1'b0; steep = 1'b0; line_live = 1'b0;
    line_shape = alr_pkg::KIND_VERT;
    colour = '0;

    // directed: idle advance, degenerate lines, each kind, wrap and restart
    add_advances(1);
    add_start(0, 0, 0, 0, 255, 255, 255);
    add_start(10, 10, 11, 11, 0, 0, 0);
    add_start(255, 0, 255, 3, 255, 0, 128);
    add_advances(3);
    add_start(255, 7, 253, 7, 1, 128, 254);
    add_advances(1);
    add_start(5, 0, 2, 3, 200, 100, 50);
    add_advances(2);
    add_start(250, 254, 255, 255, 255, 255, 255);
    add_advances(3);
    add_start(10, 20, 8, 27, 255, 170, 85);
    add_advances(4);
    add_start(0, 0, 255, 255, 17, 34, 51);
    add_advances(1);
    add_start(0, 255, 255, 1, 255, 0, 255);
    add_advances(1);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        add_advances(1);
        random_items++;
        continue;
      end
      longish = $urandom_range(0, 9) == 0;
      span = longish ? $urandom_range(16, 255) : $urandom_range(0, 12);
      shape = $urandom_range(0, 9);
      if (shape < 2) begin
        ddx = 0; ddy = span;
      end else if (shape < 4) begin
        ddx = span; ddy = 0;
      end else if (shape < 6) begin
        ddx = span; ddy = span;
      end else if ($urandom_range(0, 1) != 0) begin
        ddx = span; ddy = $urandom_range(0, span);
      end else begin
        ddx = $urandom_range(0, span); ddy = span;
      end
      x0 = $urandom_range(0, 255);
      y0 = $urandom_range(0, 255);
      x1 = pick_end(x0, ddx);
      y1 = pick_end(y0, ddy);
      add_start(x0, y0, x1, y1, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255));
      adx = (x1 > x0) ? x1 - x0 : x0 - x1;
      ady = (y1 > y0) ? y1 - y0 : y0 - y1;
      len = (adx > ady) ? adx : ady;
      if (adx == 0 || ady == 0 || adx == ady) need = (len >= 2) ? len - 1 : 0;
      else need = (len + 1) / 2;
      if (longish) steps = $urandom_range(0, 6);
      else if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, need);
      else steps = need + $urandom_range(0, 1);
      add_advances(steps);
      random_items += 1 + steps;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (word_queue.size() != 0 || in_ch.valid) @(negedge clk);
    while (due_pixels.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (due_pixels.size() != 0) begin
      $display("%0d expected pixel words never arrived", due_pixels.size());
      error_count += due_pixels.size();
    end

    $display("%0d words in, %0d lines drawn (vert %0d, horz %0d, diag %0d, wu %0d)",
             words_taken, shape_tally[0] + shape_tally[1] + shape_tally[2] + shape_tally[3],
             shape_tally[0], shape_tally[1], shape_tally[2], shape_tally[3]);
    $display("%0d pixel words checked, %0d errors", pixels_seen, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/alr_pkg.sv
sv/alr_in_if.sv
sv/alr_out_if.sv
sv/alr_div.sv
sv/alr_scale.sv
sv/antialiased_line_rasterizer_core.sv
test/antialiased_line_rasterizer_core_test.sv
